[sv/enlp_pkg.sv]
// enlp_pkg: widths, codes and payload types of the effector target nlerp unit
// depends on nothing; every other file of the block imports it
`timescale 1ns / 1ps
`default_nettype none

package enlp_pkg;

  // coordinate and weight formats
  localparam int CW    = 32;          // signed q16.16 coordinate
  localparam int WW    = 17;          // unsigned q1.16 weight, used up to 1.0
  localparam int FRAC  = 16;          // fraction bits of both formats
  localparam int DW    = CW + 1;      // difference, magnitude and length width
  localparam int SQW   = 2 * DW;      // square, sum of squares, scaled numerator
  localparam int RMW   = DW + 2;      // square root partial remainder
  localparam int PW    = DW + WW + 1; // signed weight times difference
  localparam int PTW   = DW + WW;     // weight times length

  localparam logic [WW-1:0] WONE = WW'(1 << FRAC);
  localparam int ROUND_HALF = 1 << (FRAC - 1);

  // lane of each vector in a set of three
  localparam int VEC_E = 0;           // effector minus base
  localparam int VEC_T = 1;           // target minus base
  localparam int VEC_A = 2;           // blended point minus base

  // accept to strobe, in cycles
  localparam int LATENCY = 14 + 2 * DW;

  typedef logic [2:0][CW-1:0] coord3_t;
  typedef logic [2:0][DW-1:0] mag3_t;
  typedef mag3_t [2:0]        mag_set_t;

  typedef struct packed {
    logic signed [CW-1:0] effector_x;
    logic signed [CW-1:0] effector_y;
    logic signed [CW-1:0] effector_z;
    logic signed [CW-1:0] target_x;
    logic signed [CW-1:0] target_y;
    logic signed [CW-1:0] target_z;
    logic signed [CW-1:0] base_x;
    logic signed [CW-1:0] base_y;
    logic signed [CW-1:0] base_z;
    logic [WW-1:0]        blend_weight;
    logic                 use_nlerp;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] result_x;
    logic signed [CW-1:0] result_y;
    logic signed [CW-1:0] result_z;
    logic                 zero_direction;
  } out_t;

  // per item data that rides along the length and scaling pipelines
  typedef struct packed {
    logic          nl_act;   // nlerp applies: flag set and weight below one
    logic [WW-1:0] w;        // saturated weight
    logic [2:0]    ab_neg;   // sign of each blended point minus base
    mag3_t         ab_mag;   // magnitude of each blended point minus base
    coord3_t       pass;     // base when nlerp applies, blended point otherwise
  } side_t;

endpackage

`default_nettype wire

[sv/enlp_front.sv]
// enlp_front: input register, per axis lerp and base relative vectors, six stages
// depends on enlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module enlp_front import enlp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_t      in_item,
  output logic     out_valid,
  output mag_set_t out_mag,
  output side_t    out_side
);

  logic          v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  coord3_t       e1_r, t1_r, b1_r, e2_r, t2_r, b2_r, e3_r, t3_r, b3_r;
  coord3_t       e4_r, t4_r, b4_r, a4_r, pass5_r;
  logic [WW-1:0] w1_r, w2_r, w3_r, w4_r, w5_r;
  logic          nl1_r, nl2_r, nl3_r, act4_r, act5_r;
  logic [WW-1:0] w_sat;
  mag3_t         d2_r, d2_nxt, be5_r, bt5_r, ab5_r, be5_nxt, bt5_nxt, ab5_nxt;
  logic [2:0][PW-1:0] p3_r, p3_nxt;
  coord3_t       a4_nxt, pass5_nxt;
  mag_set_t      mag6_r, mag6_nxt;
  side_t         side6_r, side6_nxt;

  // weight above one is held at one
  assign w_sat = (in_item.blend_weight > WONE) ? WONE : in_item.blend_weight;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // difference target minus effector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2_nxt[i] = {t1_r[i][CW-1], t1_r[i]} - {e1_r[i][CW-1], e1_r[i]};
    end
  end

  // weight times difference
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p3_nxt[i] = $signed({1'b0, w2_r}) * $signed(d2_r[i]);
    end
  end

  // round half up and add to effector
  always_comb begin
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] sh;
    rnd = '0;
    sh  = '0;
    for (int i = 0; i < 3; i++) begin
      rnd = $signed(p3_r[i]) + $signed(PW'(ROUND_HALF));
      sh  = rnd >>> FRAC;
      a4_nxt[i] = e3_r[i] + sh[CW-1:0];
    end
  end

  // vectors from the base
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      be5_nxt[i]   = {e4_r[i][CW-1], e4_r[i]} - {b4_r[i][CW-1], b4_r[i]};
      bt5_nxt[i]   = {t4_r[i][CW-1], t4_r[i]} - {b4_r[i][CW-1], b4_r[i]};
      ab5_nxt[i]   = {a4_r[i][CW-1], a4_r[i]} - {b4_r[i][CW-1], b4_r[i]};
      pass5_nxt[i] = act4_r ? b4_r[i] : a4_r[i];
    end
  end

  // magnitudes and signs
  always_comb begin
    side6_nxt.nl_act = act5_r;
    side6_nxt.w      = w5_r;
    side6_nxt.pass   = pass5_r;
    for (int i = 0; i < 3; i++) begin
      mag6_nxt[VEC_E][i]  = be5_r[i][DW-1] ? (DW'(0) - be5_r[i]) : be5_r[i];
      mag6_nxt[VEC_T][i]  = bt5_r[i][DW-1] ? (DW'(0) - bt5_r[i]) : bt5_r[i];
      mag6_nxt[VEC_A][i]  = ab5_r[i][DW-1] ? (DW'(0) - ab5_r[i]) : ab5_r[i];
      side6_nxt.ab_neg[i] = ab5_r[i][DW-1];
      side6_nxt.ab_mag[i] = mag6_nxt[VEC_A][i];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    e1_r    <= {in_item.effector_z, in_item.effector_y, in_item.effector_x};
    t1_r    <= {in_item.target_z, in_item.target_y, in_item.target_x};
    b1_r    <= {in_item.base_z, in_item.base_y, in_item.base_x};
    w1_r    <= w_sat;
    nl1_r   <= in_item.use_nlerp;
    d2_r    <= d2_nxt;
    e2_r    <= e1_r;
    t2_r    <= t1_r;
    b2_r    <= b1_r;
    w2_r    <= w1_r;
    nl2_r   <= nl1_r;
    p3_r    <= p3_nxt;
    e3_r    <= e2_r;
    t3_r    <= t2_r;
    b3_r    <= b2_r;
    w3_r    <= w2_r;
    nl3_r   <= nl2_r;
    a4_r    <= a4_nxt;
    e4_r    <= e3_r;
    t4_r    <= t3_r;
    b4_r    <= b3_r;
    w4_r    <= w3_r;
    act4_r  <= nl3_r && (w3_r < WONE);
    be5_r   <= be5_nxt;
    bt5_r   <= bt5_nxt;
    ab5_r   <= ab5_nxt;
    pass5_r <= pass5_nxt;
    w5_r    <= w4_r;
    act5_r  <= act4_r;
    mag6_r  <= mag6_nxt;
    side6_r <= side6_nxt;
  end

  assign out_valid = v6_r;
  assign out_mag   = mag6_r;
  assign out_side  = side6_r;

endmodule

`default_nettype wire

[sv/enlp_norm.sv]
// enlp_norm: three vector lengths, squares, sums and a one bit per stage square root
// depends on enlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module enlp_norm import enlp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  mag_set_t in_mag,
  input  side_t    in_side,
  output logic     out_valid,
  output mag3_t    out_len,
  output side_t    out_side
);

  typedef logic [2:0][SQW-1:0] sq3_t;
  typedef logic [2:0][RMW-1:0] rem3_t;

  logic [2:0][2:0][SQW-1:0] sq1_r, sq1_nxt;
  sq3_t  s2_r, c2_r;
  logic  v1_r, v2_r;
  side_t side1_r, side2_r;

  sq3_t  rad_r  [0:DW];
  rem3_t rem_r  [0:DW];
  mag3_t root_r [0:DW];
  side_t side_r [0:DW];
  logic  vld_r  [0:DW];
  sq3_t  rad0_nxt;

  // squares of every component
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        sq1_nxt[v][i] = in_mag[v][i] * in_mag[v][i];
      end
    end
  end

  // sum of squares, second add
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      rad0_nxt[v] = s2_r[v] + c2_r[v];
    end
  end

  // valid through the sum stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      vld_r[0] <= v2_r;
    end
  end

  // sum stages, root starts at zero
  always_ff @(posedge clk) begin
    sq1_r   <= sq1_nxt;
    side1_r <= in_side;
    for (int v = 0; v < 3; v++) begin
      s2_r[v] <= sq1_r[v][0] + sq1_r[v][1];
      c2_r[v] <= sq1_r[v][2];
    end
    side2_r   <= side1_r;
    rad_r[0]  <= rad0_nxt;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= side2_r;
  end

  // one root bit per stage, two radicand bits shifted in
  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    rem3_t rem_nxt;
    mag3_t root_nxt;
    sq3_t  rad_nxt;

    always_comb begin
      logic [RMW-1:0] rs;
      logic [RMW-1:0] tr;
      rs = '0;
      tr = '0;
      for (int v = 0; v < 3; v++) begin
        rs = {rem_r[k][v][RMW-3:0], rad_r[k][v][SQW-1 -: 2]};
        tr = {root_r[k][v], 2'b01};
        if (rs >= tr) begin
          rem_nxt[v]  = rs - tr;
          root_nxt[v] = {root_r[k][v][DW-2:0], 1'b1};
        end else begin
          rem_nxt[v]  = rs;
          root_nxt[v] = {root_r[k][v][DW-2:0], 1'b0};
        end
        rad_nxt[v] = {rad_r[k][v][SQW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      rad_r[k+1]  <= rad_nxt;
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = vld_r[DW];
  assign out_len   = root_r[DW];
  assign out_side  = side_r[DW];

endmodule

`default_nettype wire

[sv/enlp_scale.sv]
// enlp_scale: target distance, scaled direction by pipelined division, saturation
// depends on enlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module enlp_scale import enlp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  mag3_t in_len,
  input  side_t in_side,
  output logic  out_valid,
  output out_t  out_item
);

  typedef logic [2:0][SQW-1:0] sq3_t;

  logic            v1_r, v2_r, v3_r, out_valid_r;
  logic [PTW-1:0]  pt1_r, pe1_r;
  logic [PTW:0]    dsum;
  logic [DW-1:0]   la1_r, la2_r, la3_r, dist2_r;
  side_t           side1_r, side2_r, side3_r;
  logic [WW-1:0]   wc;
  sq3_t            prod3_r;
  mag3_t           rem0_nxt, nq0_nxt;
  out_t            out_item_r, out_item_nxt;

  mag3_t           rem_r  [0:DW];
  mag3_t           nq_r   [0:DW];
  logic [DW-1:0]   den_r  [0:DW];
  side_t           side_r [0:DW];
  logic            vld_r  [0:DW];

  // weighted lengths
  assign wc = WONE - in_side.w;

  // distance rounded half up
  assign dsum = {1'b0, pt1_r} + {1'b0, pe1_r} + (PTW+1)'(ROUND_HALF);

  // numerator with half divisor, split into remainder and quotient halves
  always_comb begin
    logic [SQW-1:0] num;
    num = '0;
    for (int i = 0; i < 3; i++) begin
      num         = prod3_r[i] + SQW'(la3_r >> 1);
      rem0_nxt[i] = num[SQW-1:DW];
      nq0_nxt[i]  = num[DW-1:0];
    end
  end

  // valid through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      vld_r[0] <= v3_r;
    end
  end

  // distance and numerator stages
  always_ff @(posedge clk) begin
    pt1_r   <= in_side.w * in_len[VEC_T];
    pe1_r   <= wc * in_len[VEC_E];
    la1_r   <= in_len[VEC_A];
    side1_r <= in_side;
    dist2_r <= dsum[FRAC +: DW];
    la2_r   <= la1_r;
    side2_r <= side1_r;
    for (int i = 0; i < 3; i++) begin
      prod3_r[i] <= side2_r.ab_mag[i] * dist2_r;
    end
    la3_r     <= la2_r;
    side3_r   <= side2_r;
    rem_r[0]  <= rem0_nxt;
    nq_r[0]   <= nq0_nxt;
    den_r[0]  <= la3_r;
    side_r[0] <= side3_r;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    mag3_t rem_nxt;
    mag3_t nq_nxt;

    always_comb begin
      logic [DW:0] rs;
      logic [DW:0] rm;
      logic        qb;
      rs = '0;
      rm = '0;
      qb = 1'b0;
      for (int i = 0; i < 3; i++) begin
        rs = {rem_r[k][i], nq_r[k][i][DW-1]};
        if (rs >= {1'b0, den_r[k]}) begin
          rm = rs - {1'b0, den_r[k]};
          qb = 1'b1;
        end else begin
          rm = rs;
          qb = 1'b0;
        end
        rem_nxt[i] = rm[DW-1:0];
        nq_nxt[i]  = {nq_r[k][i][DW-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k+1]  <= rem_nxt;
      nq_r[k+1]   <= nq_nxt;
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  // offset from base, saturate, select
  always_comb begin
    logic [CW+1:0] px;
    logic [CW+1:0] qx;
    logic [CW+1:0] sum;
    logic          zero;
    coord3_t       res;
    px   = '0;
    qx   = '0;
    sum  = '0;
    res  = '0;
    zero = (den_r[DW] == '0);
    for (int i = 0; i < 3; i++) begin
      px  = {{2{side_r[DW].pass[i][CW-1]}}, side_r[DW].pass[i]};
      qx  = {{(CW+2-DW){1'b0}}, nq_r[DW][i]};
      sum = side_r[DW].ab_neg[i] ? (px - qx) : (px + qx);
      if (!side_r[DW].nl_act || zero) begin
        res[i] = side_r[DW].pass[i];
      end else if ((sum[CW+1:CW-1] == 3'b000) || (sum[CW+1:CW-1] == 3'b111)) begin
        res[i] = sum[CW-1:0];
      end else if (sum[CW+1]) begin
        res[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    out_item_nxt.result_x       = res[0];
    out_item_nxt.result_y       = res[1];
    out_item_nxt.result_z       = res[2];
    out_item_nxt.zero_direction = side_r[DW].nl_act && zero;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[sv/effector_target_nlerp_unit.sv]
// effector_target_nlerp_unit: top level, front lerp, length unit and scaling unit
// depends on enlp_pkg, enlp_front, enlp_norm, enlp_scale
//
// Takes one item in every clock cycle: busy never rises, so an item is taken
// whenever start is high. The result of each item appears on out_item with
// out_strobe high for one cycle, in order after its start beat; the receiver
// cannot hold it off. The pipeline is made of the square root and the
// divider, each producing one bit of its 33 bit result per stage, plus
// fourteen stages of lerp, squaring, distance and output.
// With use_nlerp set and weight below one the blended point is pulled onto
// the base sphere; a blended point on the base gives the base and raises
// zero_direction.
`timescale 1ns / 1ps
`default_nettype none

module effector_target_nlerp_unit import enlp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_strobe,
  output out_t out_item
);

  logic     front_valid, norm_valid;
  mag_set_t front_mag;
  side_t    front_side, norm_side;
  mag3_t    norm_len;

  // fully pipelined, never stalls
  assign busy = 1'b0;

  enlp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_item),
    .out_valid (front_valid),
    .out_mag   (front_mag),
    .out_side  (front_side)
  );

  enlp_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_mag    (front_mag),
    .in_side   (front_side),
    .out_valid (norm_valid),
    .out_len   (norm_len),
    .out_side  (norm_side)
  );

  enlp_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (norm_valid),
    .in_len    (norm_len),
    .in_side   (norm_side),
    .out_valid (out_strobe),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[sv/enlp_checker.sv]
// enlp_checker: port level checks of the effector target nlerp unit, bound to the top
// depends on enlp_pkg and effector_target_nlerp_unit
`timescale 1ns / 1ps
`default_nettype none

module enlp_checker import enlp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_item,
  input logic out_strobe,
  input out_t out_item
);

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] warm_cnt_r;
  logic             warm;

  // cycles since reset, held at the latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else if (warm_cnt_r != CNT_W'(LATENCY)) begin
      warm_cnt_r <= warm_cnt_r + 1'b1;
    end
  end

  assign warm = (warm_cnt_r == CNT_W'(LATENCY));

  // one strobe per accepted beat, fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_strobe == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match accepted beat");

  // zero direction gives the base
  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.zero_direction) |->
      ($past(in_item.use_nlerp, LATENCY) &&
       out_item.result_x == $past(in_item.base_x, LATENCY) &&
       out_item.result_y == $past(in_item.base_y, LATENCY) &&
       out_item.result_z == $past(in_item.base_z, LATENCY)))
    else $error("zero direction result is not the base");

  // full weight gives the target
  a_full_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_item.blend_weight, LATENCY) >= WONE) |->
      (!out_item.zero_direction &&
       out_item.result_x == $past(in_item.target_x, LATENCY) &&
       out_item.result_y == $past(in_item.target_y, LATENCY) &&
       out_item.result_z == $past(in_item.target_z, LATENCY)))
    else $error("full weight result is not the target");

  // zero weight without nlerp gives the effector
  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_item.blend_weight, LATENCY) == '0 &&
     !$past(in_item.use_nlerp, LATENCY)) |->
      (!out_item.zero_direction &&
       out_item.result_x == $past(in_item.effector_x, LATENCY) &&
       out_item.result_y == $past(in_item.effector_y, LATENCY) &&
       out_item.result_z == $past(in_item.effector_z, LATENCY)))
    else $error("zero weight result is not the effector");

endmodule

bind effector_target_nlerp_unit enlp_checker u_enlp_checker (.*);

`default_nettype wire

[test/effector_target_nlerp_unit_tb.sv]
// effector_target_nlerp_unit_tb: self-checking bench for the effector target nlerp unit
// depends on enlp_pkg and effector_target_nlerp_unit; predicts each beat in exact arithmetic
`timescale 1ns / 1ps

module effector_target_nlerp_unit_tb;
  import enlp_pkg::*;

  localparam int WATCH_LIMIT = 4 * LATENCY + 400;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  // expected blended targets and their checking
  class target_board;
    out_t pending[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endfunction

    // integer square root, truncated
    function automatic logic [127:0] isqrt(logic [127:0] s);
      logic [127:0] r, c;
      r = '0;
      for (int k = 52; k >= 0; k--) begin
        c = r | (128'd1 << k);
        if (c * c <= s) r = c;
      end
      return r;
    endfunction

    function automatic logic [127:0] mag(longint x);
      logic [127:0] m;
      m = (x < 0) ? 128'(-x) : 128'(x);
      return m;
    endfunction

    function automatic logic [127:0] vec_len(longint x, longint y, longint z);
      return isqrt(mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z));
    endfunction

    function automatic logic [CW-1:0] clamp(logic signed [127:0] r);
      logic signed [127:0] v;
      v = r;
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < COORD_MIN) v = COORD_MIN;
      return v[CW-1:0];
    endfunction

    function automatic out_t blend_target(in_t it);
      longint e[3], t[3], b[3], a[3], ab[3];
      longint w;
      logic [127:0] le, lt, la, span, q;
      logic signed [127:0] r[3];
      out_t o;
      e = '{it.effector_x, it.effector_y, it.effector_z};
      t = '{it.target_x, it.target_y, it.target_z};
      b = '{it.base_x, it.base_y, it.base_z};
      w = (it.blend_weight > WONE) ? longint'(WONE) : longint'(it.blend_weight);
      o.zero_direction = 1'b0;
      // lerp with rounding half toward +infinity
      for (int i = 0; i < 3; i++) begin
        a[i] = e[i] + ((w * (t[i] - e[i]) + 32768) >>> 16);
        r[i] = a[i];
        ab[i] = a[i] - b[i];
      end
      // pin to the base sphere
      if (it.use_nlerp && w < longint'(WONE)) begin
        le = vec_len(e[0] - b[0], e[1] - b[1], e[2] - b[2]);
        lt = vec_len(t[0] - b[0], t[1] - b[1], t[2] - b[2]);
        la = vec_len(ab[0], ab[1], ab[2]);
        if (la == 0) begin
          for (int i = 0; i < 3; i++) r[i] = b[i];
          o.zero_direction = 1'b1;
        end else begin
          span = (128'(w) * lt + 128'(65536 - w) * le + 32768) >> 16;
          for (int i = 0; i < 3; i++) begin
            q = (mag(ab[i]) * span + (la >> 1)) / la;
            r[i] = b[i];
            r[i] = (ab[i] < 0) ? r[i] - $signed(q) : r[i] + $signed(q);
          end
        end
      end
      o.result_x = clamp(r[0]);
      o.result_y = clamp(r[1]);
      o.result_z = clamp(r[2]);
      return o;
    endfunction

    function void note(in_t it);
      pending.push_back(blend_target(it));
    endfunction

    function void check(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", got.result_x, '0);
        return;
      end
      want = pending.pop_front();
      if (got.result_x !== want.result_x) report("result_x", got.result_x, want.result_x);
      if (got.result_y !== want.result_y) report("result_y", got.result_y, want.result_y);
      if (got.result_z !== want.result_z) report("result_z", got.result_z, want.result_z);
      if (got.zero_direction !== want.zero_direction)
        report("zero_direction", 32'(got.zero_direction), 32'(want.zero_direction));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_strobe;
  out_t out_item;
  int   idle_pct;
  int   quiet;
  target_board board;

  effector_target_nlerp_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor both channels and watch for a stall
  always @(posedge clk) begin
    if (rst_n && start && !busy) board.note(in_item);
    if (rst_n && out_strobe) board.check(out_item);
    if (rst_n && !(start && !busy) && !out_strobe) quiet <= quiet + 1;
    else quiet <= 0;
    if (quiet >= WATCH_LIMIT) begin
      $display("[effector_target_nlerp_unit] ERROR");
      $finish;
    end
  end

  // send one beat, holding start until taken, then maybe a gap
  task automatic send(in_t it);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(0, 1 << 21) - (1 << 20);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 1 << 27) - (1 << 26);
    endcase
  endfunction

  function automatic logic [WW-1:0] rand_weight();
    case ($urandom_range(7))
      0: return WONE;
      1: return '0;
      2: return WW'($urandom_range(131071));
      default: return WW'($urandom_range(65535));
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.effector_x = rand_coord();
    it.effector_y = rand_coord();
    it.effector_z = rand_coord();
    it.target_x = rand_coord();
    it.target_y = rand_coord();
    it.target_z = rand_coord();
    // base near the effector half of the time so lengths stay moderate
    it.base_x = $urandom_range(1) ? rand_coord() : it.effector_x + ($urandom_range(255) - 128);
    it.base_y = $urandom_range(1) ? rand_coord() : it.effector_y + ($urandom_range(255) - 128);
    it.base_z = $urandom_range(1) ? rand_coord() : it.effector_z + ($urandom_range(255) - 128);
    it.blend_weight = rand_weight();
    it.use_nlerp = ($urandom_range(3) != 0);
    // blended point on the base now and then
    if ($urandom_range(19) == 0) begin
      it.blend_weight = '0;
      it.base_x = it.effector_x;
      it.base_y = it.effector_y;
      it.base_z = it.effector_z;
    end
    return it;
  endfunction

  function automatic in_t fill_item(logic [CW-1:0] e, logic [CW-1:0] t, logic [CW-1:0] b,
                                    logic [WW-1:0] w, logic nl);
    in_t it;
    it = '{e, e, e, t, t, t, b, b, b, w, nl};
    return it;
  endfunction

  initial begin
    in_t it;
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    idle_pct = 17;
    quiet = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, weights at and above one, nlerp on and off, zero direction
    send(fill_item(32'h7fff_ffff, 32'h8000_0000, 32'h0, WONE, 1'b1));
    send(fill_item(32'h8000_0000, 32'h7fff_ffff, 32'h0, '0, 1'b1));
    send(fill_item(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 17'h1ffff, 1'b1));
    send(fill_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 17'h8000, 1'b0));
    send(fill_item(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 17'h8000, 1'b1));
    send(fill_item(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 17'h0ffff, 1'b1));
    send(fill_item(32'h0001_0000, 32'h0005_0000, 32'h0001_0000, '0, 1'b1));
    send(fill_item(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 17'h4000, 1'b1));
    send(fill_item(32'h0, 32'h0, 32'h0, 17'h1ffff, 1'b1));
    send(fill_item(32'h0003_0000, 32'hfffd_0000, 32'h0, 17'h8000, 1'b1));
    send(fill_item(32'h0003_0000, 32'hfffd_0000, 32'h0, 17'h8000, 1'b0));
    send(fill_item(32'hffff_ffff, 32'h0000_0001, 32'h0, 17'h8000, 1'b0));
    send(fill_item(32'h1234_5678, 32'hedcb_a987, 32'h0100_0000, 17'h0001, 1'b1));
    send(fill_item(32'h1234_5678, 32'hedcb_a987, 32'h0100_0000, 17'h1_0001, 1'b0));
    it = fill_item(32'h0002_0000, 32'h0004_0000, 32'h0, 17'h6000, 1'b1);
    it.effector_y = 32'hfff0_0000;
    it.target_z = 32'h7fff_0000;
    send(it);
    drain();

    // random, three idling phases with the sender pausing for a full drain between
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 17 : (ph == 1) ? 68 : 0;
      for (int n = 0; n < 215; n++) send(rand_item());
      drain();
    end

    start <= 1'b0;
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[effector_target_nlerp_unit] OK");
    else
      $display("[effector_target_nlerp_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
sv/enlp_pkg.sv
sv/enlp_front.sv
sv/enlp_norm.sv
sv/enlp_scale.sv
sv/effector_target_nlerp_unit.sv
sv/enlp_checker.sv
test/effector_target_nlerp_unit_tb.sv
